/* rtl/sqw_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the square-wave sample mixer.
// No dependencies; every other file of the block depends on this package.
package sqw_pkg;

	// Widths of the sample path and of the configuration port.
	localparam int SAMPLE_W            = 32;
	localparam int CFG_DATA_W          = 32;
	localparam int REG_INDEX_W         = 3;
	localparam int LENGTH_BITS_DEFAULT = 24;

	// Register indexes of the configuration port.
	typedef enum logic [REG_INDEX_W-1:0] {
		REG_HIGH_LENGTH       = 3'd0,
		REG_LOW_LENGTH        = 3'd1,
		REG_FIRST_HIGH_LENGTH = 3'd2,
		REG_HIGH_LEVEL        = 3'd3,
		REG_LOW_LEVEL         = 3'd4
	} reg_index_t;

	// Operation applied to the sample and the wave level.
	typedef enum logic [1:0] {
		MODE_SET = 2'd0,
		MODE_ADD = 2'd1,
		MODE_AND = 2'd2,
		MODE_SUB = 2'd3
	} mode_t;

	// Wave phase, one-hot.
	typedef enum logic [2:0] {
		PH_FIRST = 3'b001,
		PH_LOW   = 3'b010,
		PH_HIGH  = 3'b100
	} phase_t;

	localparam logic signed [SAMPLE_W-1:0] HIGH_LEVEL_RESET = SAMPLE_W'(1);
	localparam logic signed [SAMPLE_W-1:0] LOW_LEVEL_RESET  = '0;

endpackage

/* rtl/sqw_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on sqw_pkg for the payload widths and the mode type.
interface sqw_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [sqw_pkg::SAMPLE_W-1:0]    sample_in;
	sqw_pkg::mode_t                         mode;

	modport source (output valid, output sample_in, output mode, input ready);
	modport sink   (input valid, input sample_in, input mode, output ready);
endinterface

interface sqw_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [sqw_pkg::SAMPLE_W-1:0]    sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

/* rtl/sqw_phase.sv */
`timescale 1ns / 1ps
// Phase and offset counter of the square wave; steps once per sample.
// Depends on sqw_pkg for the phase type.
module sqw_phase #(
	parameter int LENGTH_BITS = sqw_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [LENGTH_BITS-1:0] high_length,
	input  logic [LENGTH_BITS-1:0] low_length,
	input  logic [LENGTH_BITS-1:0] first_high_length,
	output logic                   sel_low
);
	import sqw_pkg::*;

	phase_t                 phase_q, phase_1, phase_2, phase_d;
	logic [LENGTH_BITS-1:0] offset_q, offset_1, offset_2, offset_inc, offset_d;
	logic [LENGTH_BITS-1:0] len_0, len_1, len_2;
	logic                   hold;

	function automatic logic [LENGTH_BITS-1:0] len_of(input phase_t p);
		logic [LENGTH_BITS-1:0] len;
		unique case (p)
			PH_FIRST: len = (first_high_length != '0) ? first_high_length : high_length;
			PH_LOW:   len = (low_length != '0) ? low_length : high_length;
			default:  len = high_length;
		endcase
		return len;
	endfunction

	function automatic phase_t next_of(input phase_t p);
		return (p == PH_LOW) ? PH_HIGH : PH_LOW;
	endfunction

	// Up to two phases may end without using a sample before this one is used.
	always_comb begin
		len_0    = len_of(phase_q);
		phase_1  = (offset_q == len_0) ? next_of(phase_q) : phase_q;
		offset_1 = (offset_q == len_0) ? '0 : offset_q;
		len_1    = len_of(phase_1);
		phase_2  = (offset_1 == len_1) ? next_of(phase_1) : phase_1;
		offset_2 = (offset_1 == len_1) ? '0 : offset_1;
		len_2    = len_of(phase_2);
		hold     = (offset_2 == len_2);
		offset_inc = offset_2 + LENGTH_BITS'(1);

		if (hold) begin
			phase_d  = phase_2;
			offset_d = offset_2;
		end else if (offset_inc >= len_2) begin
			phase_d  = next_of(phase_2);
			offset_d = '0;
		end else begin
			phase_d  = phase_2;
			offset_d = offset_inc;
		end
	end

	assign sel_low = (phase_2 == PH_LOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			offset_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			offset_q <= offset_d;
		end
	end

endmodule

/* rtl/sqw_mix.sv */
`timescale 1ns / 1ps
// Combines a sample with the wave level by set, add, and or subtract.
// Depends on sqw_pkg for the mode codes and the sample width.
module sqw_mix (
	input  logic signed [sqw_pkg::SAMPLE_W-1:0] sample,
	input  sqw_pkg::mode_t                      mode,
	input  logic signed [sqw_pkg::SAMPLE_W-1:0] level,
	output logic signed [sqw_pkg::SAMPLE_W-1:0] result
);
	import sqw_pkg::*;

	// Add and subtract wrap modulo 2^32.
	always_comb begin
		unique case (mode)
			MODE_SET: result = level;
			MODE_ADD: result = sample + level;
			MODE_AND: result = sample & level;
			MODE_SUB: result = sample - level;
			default:  result = level;
		endcase
	end

endmodule

/* rtl/square_wave_sample_mixer.sv */
`timescale 1ns / 1ps
// Square-wave sample mixer: one result transaction per sample transaction, one per clock
// sustained while results are taken without back-pressure. A sample is captured in an input
// register, combined with the current wave level in combinational logic (the phase compare
// chain and a 32-bit add) and held in a result register, from which it is offered. While a
// finished result waits to be taken, the input register can still take one more
// transaction; after that the input stalls until the result is taken. Configuration must be
// written by the user only while no transaction is in flight; the block does not enforce this.
//
// Depends on sqw_pkg, sqw_in_if, sqw_out_if, sqw_phase and sqw_mix.
module square_wave_sample_mixer #(
	parameter int LENGTH_BITS = sqw_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	sqw_in_if.sink                             samples,
	sqw_out_if.source                          results,
	input  logic                               cfg_we,
	input  logic [sqw_pkg::REG_INDEX_W-1:0]    cfg_index,
	input  logic [sqw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import sqw_pkg::*;

	// Configuration registers. Length registers take the low LENGTH_BITS of the data.
	logic [LENGTH_BITS-1:0]     high_length_q, low_length_q, first_high_length_q;
	logic signed [SAMPLE_W-1:0] high_level_q, low_level_q;

	// Input register stage.
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	mode_t                      mode_s1;

	// Result register stage.
	logic                       valid_s2;
	logic signed [SAMPLE_W-1:0] sample_out_s2;

	logic                       advance;
	logic                       sel_low;
	logic signed [SAMPLE_W-1:0] level;
	logic signed [SAMPLE_W-1:0] mixed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_length_q       <= '0;
			low_length_q        <= '0;
			first_high_length_q <= '0;
			high_level_q        <= HIGH_LEVEL_RESET;
			low_level_q         <= LOW_LEVEL_RESET;
		end else if (cfg_we) begin
			// Writes to indexes beyond the register list are dropped.
			unique case (cfg_index)
				REG_HIGH_LENGTH:       high_length_q       <= cfg_wdata[LENGTH_BITS-1:0];
				REG_LOW_LENGTH:        low_length_q        <= cfg_wdata[LENGTH_BITS-1:0];
				REG_FIRST_HIGH_LENGTH: first_high_length_q <= cfg_wdata[LENGTH_BITS-1:0];
				REG_HIGH_LEVEL:        high_level_q        <= cfg_wdata[SAMPLE_W-1:0];
				REG_LOW_LEVEL:         low_level_q         <= cfg_wdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// The item in the input register moves on whenever the result register is empty
	// or its transaction completes in this cycle. The wave steps with that move.
	assign advance       = valid_s1 && (!valid_s2 || results.ready);
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1 <= samples.sample_in;
			mode_s1   <= samples.mode;
		end
	end

	sqw_phase #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_phase (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (advance),
		.high_length       (high_length_q),
		.low_length        (low_length_q),
		.first_high_length (first_high_length_q),
		.sel_low           (sel_low)
	);

	// The low level applies only in low phases; the first and steady high phases
	// both use the high level.
	assign level = sel_low ? low_level_q : high_level_q;

	sqw_mix u_mix (
		.sample (sample_s1),
		.mode   (mode_s1),
		.level  (level),
		.result (mixed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_out_s2 <= mixed;
		end
	end

	assign results.valid      = valid_s2;
	assign results.sample_out = sample_out_s2;

endmodule

/* rtl/sqw_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the square-wave sample mixer, bound to the top level.
// Depends on sqw_pkg for the sample width and on square_wave_sample_mixer's ports.
module sqw_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [sqw_pkg::SAMPLE_W-1:0]     sample_out
);

	// A pending result stays offered until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped before its transaction completed");

	// A pending result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample_out))
		else $error("result changed while stalled");

	// With no result pending, the block always takes a new sample.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the result register is empty");

	// A sample accepted while no result is pending shows a result once it reaches the result register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> ##1 out_valid)
		else $error("accepted transaction produced no result");

endmodule

bind square_wave_sample_mixer sqw_checker u_sqw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.sample_out (results.sample_out)
);
